// ===== hw/rtl/msc_pkg.sv =====
`timescale 1ns / 1ps

package msc_pkg;

    localparam logic [1:0] CHARSET_ASCII  = 2'd0;
    localparam logic [1:0] CHARSET_SJIS   = 2'd1;
    localparam logic [1:0] CHARSET_EUC_JP = 2'd2;
    localparam logic [1:0] CHARSET_UNUSED = 2'd3;
    localparam logic [1:0] CHARSET_RESET  = CHARSET_SJIS;

    localparam logic [1:0] ORDER_EQUAL   = 2'd0;
    localparam logic [1:0] ORDER_LESS    = 2'd1;
    localparam logic [1:0] ORDER_GREATER = 2'd2;

    localparam int POS_W = 16;

    typedef struct packed {
        logic [1:0] trail_count;
        logic       fold_equal;
    } byte_class_t;

endpackage

// ===== hw/rtl/msc_byte_class.sv =====
`timescale 1ns / 1ps

module msc_byte_class
    import msc_pkg::*;
(
    input  logic [1:0]  charset,
    input  logic [7:0]  byte_a,
    input  logic [7:0]  byte_b,
    output byte_class_t cls
);

    logic [7:0] upper_a;
    logic [7:0] upper_b;

    always_comb
    begin
        cls.fold_equal  = (upper_a == upper_b);
        cls.trail_count = 2'd0;
        case (charset)
            CHARSET_SJIS:
            begin
                if ((byte_a >= 8'h81 && byte_a <= 8'h9F)
                    || (byte_a >= 8'hE0 && byte_a <= 8'hEF))
                begin
                    cls.trail_count = 2'd1;
                end
            end
            CHARSET_EUC_JP:
            begin
                if (byte_a == 8'h8F)
                begin
                    cls.trail_count = 2'd2;
                end
                else if (byte_a == 8'h8E || (byte_a >= 8'hA1 && byte_a <= 8'hFE))
                begin
                    cls.trail_count = 2'd1;
                end
            end
            default:
            begin
                cls.trail_count = 2'd0;
            end
        endcase
    end

    // ascii letter case fold
    assign upper_a = (byte_a >= 8'h61 && byte_a <= 8'h7A) ? (byte_a - 8'h20) : byte_a;
    assign upper_b = (byte_b >= 8'h61 && byte_b <= 8'h7A) ? (byte_b - 8'h20) : byte_b;

endmodule

// ===== hw/rtl/multibyte_string_compare.sv =====
`timescale 1ns / 1ps
// a result is on m_tvalid in the cycle after the byte pair transfer that decides it
// one byte pair per cycle if s_tready; the result register frees in the cycle it is taken
// compare state and the output register sit between input transfer and output transfer
// reset: rst_n asynchronous, active low; clears the compare state and output valid
// reset: charset returns to sjis

module multibyte_string_compare
    import msc_pkg::*;
#(
    parameter int unsigned MAX_LEN = 65535
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // byte_a, byte_b
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // order, position, zero fill
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data   // charset
);

    localparam logic [POS_W-1:0] POS_CAP =
        (MAX_LEN < 65535) ? POS_W'(MAX_LEN) : {POS_W{1'b1}};

    logic [1:0]       charset_reg;
    logic [POS_W-1:0] byte_position_reg, byte_position_next;
    logic [1:0]       trail_left_reg, trail_left_next;
    logic [POS_W-1:0] lead_position_reg, lead_position_next;
    logic [1:0]       tie_order_reg, tie_order_next;
    logic [POS_W-1:0] tie_position_reg, tie_position_next;
    logic             out_valid_reg;
    logic [1:0]       order_reg, order_next;
    logic [POS_W-1:0] position_reg, position_next;

    logic             accept;
    logic             result;
    logic [7:0]       byte_a;
    logic [7:0]       byte_b;
    logic [1:0]       raw_order;
    logic [POS_W-1:0] pos_inc;
    byte_class_t      cls;

    assign byte_a    = s_tdata[7:0];
    assign byte_b    = s_tdata[15:8];
    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {6'd0, position_reg, order_reg};

    msc_byte_class u_class
    (
        .charset (charset_reg),
        .byte_a  (byte_a),
        .byte_b  (byte_b),
        .cls     (cls)
    );

    assign raw_order = (byte_a < byte_b) ? ORDER_LESS : ORDER_GREATER;
    assign pos_inc   = (byte_position_reg < POS_CAP) ? (byte_position_reg + 1'b1)
                                                     : byte_position_reg;

    always_comb
    begin
        result             = 1'b0;
        order_next         = ORDER_EQUAL;
        position_next      = '0;
        byte_position_next = pos_inc;
        trail_left_next    = trail_left_reg;
        lead_position_next = lead_position_reg;
        tie_order_next     = tie_order_reg;
        tie_position_next  = tie_position_reg;
        if (trail_left_reg != 2'd0)
        begin
            if (byte_a != byte_b)
            begin
                result        = 1'b1;
                order_next    = raw_order;
                position_next = lead_position_reg;
            end
            else if (byte_a == 8'd0)
            begin
                result        = 1'b1;
                order_next    = tie_order_reg;
                position_next = tie_position_reg;
            end
            else
            begin
                trail_left_next = trail_left_reg - 2'd1;
            end
        end
        else if (byte_a == byte_b)
        begin
            if (byte_a == 8'd0)
            begin
                result        = 1'b1;
                order_next    = tie_order_reg;
                position_next = tie_position_reg;
            end
            else
            begin
                trail_left_next    = cls.trail_count;
                lead_position_next = pos_inc;
            end
        end
        else if (!cls.fold_equal)
        begin
            result        = 1'b1;
            order_next    = raw_order;
            position_next = pos_inc;
        end
        else if (tie_order_reg == ORDER_EQUAL)
        begin
            tie_order_next    = raw_order;
            tie_position_next = pos_inc;
        end
        // every result ends the compare
        if (result)
        begin
            byte_position_next = '0;
            trail_left_next    = 2'd0;
            lead_position_next = '0;
            tie_order_next     = ORDER_EQUAL;
            tie_position_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            charset_reg       <= CHARSET_RESET;
            byte_position_reg <= '0;
            trail_left_reg    <= 2'd0;
            lead_position_reg <= '0;
            tie_order_reg     <= ORDER_EQUAL;
            tie_position_reg  <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                charset_reg <= cfg_data;
            end
            if (accept)
            begin
                byte_position_reg <= byte_position_next;
                trail_left_reg    <= trail_left_next;
                lead_position_reg <= lead_position_next;
                tie_order_reg     <= tie_order_next;
                tie_position_reg  <= tie_position_next;
            end
            if (accept && result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && result)
        begin
            order_reg    <= order_next;
            position_reg <= position_next;
        end
    end

`ifndef SYNTHESIS
    a_equal_no_position: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && order_reg == ORDER_EQUAL) |-> (position_reg == '0))
        else $error("equal result carries a position");

    a_order_has_position: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && order_reg != ORDER_EQUAL) |-> (position_reg != '0))
        else $error("ordered result without a position");

    a_order_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (order_reg == ORDER_EQUAL || order_reg == ORDER_LESS
                      || order_reg == ORDER_GREATER))
        else $error("undefined order code");

    a_clear_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && result) |=> (byte_position_reg == '0 && trail_left_reg == 2'd0
                                && tie_order_reg == ORDER_EQUAL))
        else $error("compare state not cleared after result");

    a_trail_after_lead: assert property (@(posedge clk) disable iff (!rst_n)
        (trail_left_reg != 2'd0) |-> (lead_position_reg != '0))
        else $error("trail bytes pending without a lead position");
`endif

endmodule
